>>> design/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types, constants and helpers for the catmull-rom sweep sampler.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_W      = 16;
    localparam int MAX_SAMPLES = 32;
    localparam int CNT_W       = 6;                  // samples_per_segment register
    localparam int J_W         = 5;                  // sample index inside a segment
    localparam int WIDE_W      = DATA_WIDTH + 16;    // intermediate pyramid values
    localparam int ACC_W       = WIDE_W + FRAC_W;    // scaled sums before rounding
    localparam int SPLIT_W     = 24;                 // low part of the split multiply
    localparam int MUL_A_W     = WIDE_W - SPLIT_W + 1;
    localparam int MUL_B_W     = FRAC_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    localparam logic [CNT_W-1:0] SPS_RESET = CNT_W'(8);

    // rounding shift codes of the shared multiply-add unit
    localparam logic [1:0] SH_8  = 2'd0;
    localparam logic [1:0] SH_17 = 2'd1;
    localparam logic [1:0] SH_24 = 2'd2;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
        logic signed [DATA_WIDTH-1:0] s;
    } point_t;

    typedef struct packed {
        logic                     start;
        logic [1:0]               shift;
        logic signed [MUL_B_W-1:0] mult;
        logic signed [WIDE_W-1:0]  diff;
        logic signed [WIDE_W-1:0]  base;
    } mac_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WIDE_W-1:0] result;
    } mac_rsp_t;

    typedef struct packed {
        logic             start;
        logic [J_W-1:0]   num;
        logic [CNT_W-1:0] den;
    } tdiv_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } tdiv_rsp_t;

    function automatic logic signed [DATA_WIDTH-1:0] comp_of(point_t p, logic [1:0] f);
        logic signed [DATA_WIDTH-1:0] v;
        case (f)
            2'd0:    v = p.x;
            2'd1:    v = p.y;
            2'd2:    v = p.z;
            default: v = p.s;
        endcase
        return v;
    endfunction

    function automatic logic signed [WIDE_W-1:0] widen(logic signed [DATA_WIDTH-1:0] v);
        return {{(WIDE_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] saturate(logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-DATA_WIDTH:0] top;
        logic signed [DATA_WIDTH-1:0] r;
        top = v[WIDE_W-1:DATA_WIDTH-1];
        if ((&top) || !(|top))
            r = v[DATA_WIDTH-1:0];
        else if (v[WIDE_W-1])
            r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        else
            r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        return r;
    endfunction

endpackage

>>> design/crs_point_if.sv
// ----------------------------------------------------------------------------
// crs_point_if
// Control point request channel: position, scale and end-of-sweep flag.
// ----------------------------------------------------------------------------
interface crs_point_if;
    import crs_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] pos_x;
    logic signed [DATA_WIDTH-1:0] pos_y;
    logic signed [DATA_WIDTH-1:0] pos_z;
    logic signed [DATA_WIDTH-1:0] scale_value;
    logic                         last_point;

    modport source (output valid, pos_x, pos_y, pos_z, scale_value, last_point,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, scale_value, last_point,
                    output ready);
endinterface

>>> design/crs_sample_if.sv
// ----------------------------------------------------------------------------
// crs_sample_if
// Curve sample request channel: interpolated point and end-of-run flag.
// ----------------------------------------------------------------------------
interface crs_sample_if;
    import crs_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    logic signed [DATA_WIDTH-1:0] out_scale;
    logic                         end_of_run;

    modport source (output valid, out_x, out_y, out_z, out_scale, end_of_run,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_scale, end_of_run,
                    output ready);
endinterface

>>> design/crs_tdiv.sv
// ----------------------------------------------------------------------------
// crs_tdiv
// Serial divider for the curve parameter: t = floor(j * 2^16 / L), one bit a cycle.
// ----------------------------------------------------------------------------
module crs_tdiv (
    input  logic               clk,
    input  logic               rst_n,
    input  crs_pkg::tdiv_req_t req,
    output crs_pkg::tdiv_rsp_t rsp
);
    import crs_pkg::*;

    localparam int ITER_W = $clog2(FRAC_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [J_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic [FRAC_W-1:0] quot_reg, quot_next;
    logic [J_W:0]      trial;

    // j < L, so the integer part of the quotient is zero and rem starts at j
    assign trial = {rem_reg, 1'b0};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= den_reg)
            begin
                rem_next  = J_W'(trial - den_reg);
                quot_next = {quot_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[J_W-1:0];
                quot_next = {quot_reg[FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ITER_W'(FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> design/crs_mac.sv
// ----------------------------------------------------------------------------
// crs_mac
// Shared multiply-add-round unit: floor((base * 2^16 + mult * diff + half) / 2^n).
// The wide diff is multiplied in two halves on one multiplier.
// ----------------------------------------------------------------------------
module crs_mac (
    input  logic              clk,
    input  logic              rst_n,
    input  crs_pkg::mac_req_t req,
    output crs_pkg::mac_rsp_t rsp
);
    import crs_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    logic [1:0]                phase_reg, phase_next;
    logic                      done_reg, done_next;
    logic signed [WIDE_W-1:0]  base_reg, diff_reg;
    logic signed [MUL_B_W-1:0] mult_reg;
    logic [1:0]                shift_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [WIDE_W-1:0]  res_reg, res_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   half;
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   shifted;

    assign mul_a = (phase_reg == PH_LOW) ? $signed({1'b0, diff_reg[SPLIT_W-1:0]})
                                         : $signed({diff_reg[WIDE_W-1],
                                                    diff_reg[WIDE_W-1:SPLIT_W]});
    assign prod  = mul_a * mult_reg;

    always_comb
    begin
        case (shift_reg)
            SH_8:    half = ACC_W'(1) << 7;
            SH_17:   half = ACC_W'(1) << 16;
            default: half = ACC_W'(1) << 23;
        endcase
    end

    // high partial product lands 24 bits up; true sums stay well inside the accumulator
    assign sum = acc_reg + $signed({prod[ACC_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}});

    always_comb
    begin
        case (shift_reg)
            SH_8:    shifted = sum >>> 8;
            SH_17:   shifted = sum >>> 17;
            default: shifted = sum >>> 24;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        res_next   = res_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                    phase_next = PH_LOW;
            end
            PH_LOW:
            begin
                acc_next   = $signed({base_reg, {FRAC_W{1'b0}}})
                           + $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod}) + half;
                phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                res_next   = shifted[WIDE_W-1:0];
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && (phase_reg == PH_IDLE))
        begin
            base_reg  <= req.base;
            diff_reg  <= req.diff;
            mult_reg  <= req.mult;
            shift_reg <= req.shift;
        end
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

>>> design/catmull_rom_sweep_sampler_unit.sv
// ----------------------------------------------------------------------------
// catmull_rom_sweep_sampler_unit
// Uniform catmull-rom sweep sampler with one shared multiply-add unit.
// ----------------------------------------------------------------------------
// Control points come in on the points channel (valid/ready). The block keeps
// the three previous points; each request that completes a segment makes it
// emit L samples of that segment on the samples channel, and a last_point
// request also emits the closing segment, then empties the window.
// end_of_run marks the final sample caused by one request. A request that
// finishes no segment just updates the window.
// L comes from the samples_per_segment register (cfg_wr_en / cfg_wr_data),
// 8 after reset, 0 read as 1 and values above 32 as 32.
// Each sample runs the serial t divider, then 24 multiply-add passes on the
// one shared multiplier (six per component, four components), then goes
// into the output register. points.ready is high only while no segment is
// in work. A stalled receiver holds the output register and the sequencer
// waits on it. Reset empties the window and the output register and
// restores L to 8.
// ----------------------------------------------------------------------------
module catmull_rom_sweep_sampler_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [crs_pkg::CNT_W-1:0]  cfg_wr_data,
    crs_point_if.sink                  points,
    crs_sample_if.source               samples
);
    import crs_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV_GO   = 3'd1;
    localparam logic [2:0] ST_DIV_WAIT = 3'd2;
    localparam logic [2:0] ST_OP_GO    = 3'd3;
    localparam logic [2:0] ST_OP_WAIT  = 3'd4;
    localparam logic [2:0] ST_OUT      = 3'd5;

    localparam logic [2:0] OP_A0 = 3'd0;
    localparam logic [2:0] OP_A1 = 3'd1;
    localparam logic [2:0] OP_A2 = 3'd2;
    localparam logic [2:0] OP_B0 = 3'd3;
    localparam logic [2:0] OP_B1 = 3'd4;
    localparam logic [2:0] OP_C  = 3'd5;

    localparam logic [1:0] COMP_LAST = 2'd3;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] sps_reg, sps_next;
    logic [1:0]       held_reg, held_next;
    point_t           w0_reg, w0_next, w1_reg, w1_next, w2_reg, w2_next;
    point_t           q0_reg, q0_next, q1_reg, q1_next, q2_reg, q2_next, q3_reg, q3_next;
    logic             seg2_reg, seg2_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [J_W-1:0]   j_reg, j_next;
    logic [FRAC_W-1:0] t_reg, t_next;
    logic [1:0]       comp_reg, comp_next;
    logic [2:0]       op_reg, op_next;
    logic signed [WIDE_W-1:0] a0_reg, a0_next, a1_reg, a1_next, a2_reg, a2_next;
    logic signed [WIDE_W-1:0] b0_reg, b0_next, b1_reg, b1_next;
    logic signed [DATA_WIDTH-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [DATA_WIDTH-1:0] cz_reg, cz_next, cs_reg, cs_next;
    logic             ov_reg, ov_next;
    logic signed [DATA_WIDTH-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic signed [DATA_WIDTH-1:0] oz_reg, oz_next, os_reg, os_next;
    logic             oe_reg, oe_next;

    point_t           in_pt;
    logic             in_acc;
    logic [CNT_W-1:0] len_eff;
    logic             last_j;
    logic signed [WIDE_W-1:0]  p0, p1, p2, p3;
    logic signed [MUL_B_W-1:0] t_pos, t_neg;
    logic signed [DATA_WIDTH-1:0] c_sat;
    mac_req_t         mac_req;
    mac_rsp_t         mac_rsp;
    tdiv_req_t        div_req;
    tdiv_rsp_t        div_rsp;

    crs_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .rsp   (mac_rsp)
    );

    crs_tdiv u_tdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_pt  = '{x: points.pos_x, y: points.pos_y, z: points.pos_z,
                      s: points.scale_value};
    assign points.ready = (state_reg == ST_IDLE);
    assign in_acc = points.valid && points.ready;

    assign len_eff = (sps_reg == '0) ? CNT_W'(1)
                   : ((sps_reg > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : sps_reg);
    assign last_j  = (CNT_W'(j_reg) + CNT_W'(1)) == len_reg;

    // operands of the pyramid step in work
    assign p0    = widen(comp_of(q0_reg, comp_reg));
    assign p1    = widen(comp_of(q1_reg, comp_reg));
    assign p2    = widen(comp_of(q2_reg, comp_reg));
    assign p3    = widen(comp_of(q3_reg, comp_reg));
    assign t_pos = $signed({1'b0, t_reg});
    assign t_neg = $signed({1'b1, t_reg});   // t - 1 in the same format
    assign c_sat = saturate(mac_rsp.result);

    always_comb
    begin
        mac_req.start = (state_reg == ST_OP_GO);
        mac_req.mult  = t_pos;
        case (op_reg)
            OP_A0:
            begin
                mac_req.base  = p1;
                mac_req.diff  = p1 - p0;
                mac_req.shift = SH_8;
            end
            OP_A1:
            begin
                mac_req.base  = p1;
                mac_req.diff  = p2 - p1;
                mac_req.shift = SH_8;
            end
            OP_A2:
            begin
                mac_req.base  = p2;
                mac_req.diff  = p3 - p2;
                mac_req.mult  = t_neg;
                mac_req.shift = SH_8;
            end
            OP_B0:
            begin
                mac_req.base  = a0_reg + a1_reg;
                mac_req.diff  = a1_reg - a0_reg;
                mac_req.shift = SH_17;
            end
            OP_B1:
            begin
                mac_req.base  = a1_reg <<< 1;
                mac_req.diff  = a2_reg - a1_reg;
                mac_req.shift = SH_17;
            end
            default:
            begin
                mac_req.base  = b0_reg;
                mac_req.diff  = b1_reg - b0_reg;
                mac_req.shift = SH_24;
            end
        endcase
    end

    assign div_req.start = (state_reg == ST_DIV_GO);
    assign div_req.num   = j_reg;
    assign div_req.den   = len_reg;

    always_comb
    begin
        state_next = state_reg;
        sps_next   = cfg_wr_en ? cfg_wr_data : sps_reg;
        held_next  = held_reg;
        w0_next    = w0_reg;
        w1_next    = w1_reg;
        w2_next    = w2_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        q2_next    = q2_reg;
        q3_next    = q3_reg;
        seg2_next  = seg2_reg;
        len_next   = len_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        comp_next  = comp_reg;
        op_next    = op_reg;
        a0_next    = a0_reg;
        a1_next    = a1_reg;
        a2_next    = a2_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        cs_next    = cs_reg;
        ov_next    = ov_reg && !samples.ready;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        os_next    = os_reg;
        oe_next    = oe_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    len_next = len_eff;
                    j_next   = '0;
                    if (held_reg >= 2'd2)
                    begin
                        q0_next    = (held_reg == 2'd3) ? w2_reg : w1_reg;
                        q1_next    = w1_reg;
                        q2_next    = w0_reg;
                        q3_next    = in_pt;
                        seg2_next  = points.last_point;
                        state_next = ST_DIV_GO;
                    end
                    else if (points.last_point && (held_reg == 2'd1))
                    begin
                        // closing segment of a two-point sweep
                        q0_next    = w0_reg;
                        q1_next    = w0_reg;
                        q2_next    = in_pt;
                        q3_next    = in_pt;
                        seg2_next  = 1'b0;
                        state_next = ST_DIV_GO;
                    end
                    if (points.last_point)
                    begin
                        held_next = '0;
                    end
                    else
                    begin
                        w2_next   = w1_reg;
                        w1_next   = w0_reg;
                        w0_next   = in_pt;
                        held_next = (held_reg == 2'd3) ? 2'd3 : held_reg + 2'd1;
                    end
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    t_next     = div_rsp.quot;
                    comp_next  = '0;
                    op_next    = OP_A0;
                    state_next = ST_OP_GO;
                end
            end
            ST_OP_GO:
            begin
                state_next = ST_OP_WAIT;
            end
            ST_OP_WAIT:
            begin
                if (mac_rsp.done)
                begin
                    state_next = ST_OP_GO;
                    op_next    = op_reg + 3'd1;
                    case (op_reg)
                        OP_A0: a0_next = mac_rsp.result;
                        OP_A1: a1_next = mac_rsp.result;
                        OP_A2: a2_next = mac_rsp.result;
                        OP_B0: b0_next = mac_rsp.result;
                        OP_B1: b1_next = mac_rsp.result;
                        default:
                        begin
                            case (comp_reg)
                                2'd0:    cx_next = c_sat;
                                2'd1:    cy_next = c_sat;
                                2'd2:    cz_next = c_sat;
                                default: cs_next = c_sat;
                            endcase
                            op_next   = OP_A0;
                            comp_next = comp_reg + 2'd1;
                            if (comp_reg == COMP_LAST)
                                state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || samples.ready)
                begin
                    ov_next = 1'b1;
                    ox_next = cx_reg;
                    oy_next = cy_reg;
                    oz_next = cz_reg;
                    os_next = cs_reg;
                    oe_next = last_j && !seg2_reg;
                    if (last_j)
                    begin
                        j_next = '0;
                        if (seg2_reg)
                        begin
                            // closing segment reuses the end point twice
                            q0_next    = q1_reg;
                            q1_next    = q2_reg;
                            q2_next    = q3_reg;
                            seg2_next  = 1'b0;
                            state_next = ST_DIV_GO;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + J_W'(1);
                        state_next = ST_DIV_GO;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sps_reg   <= SPS_RESET;
            held_reg  <= '0;
            seg2_reg  <= 1'b0;
            len_reg   <= CNT_W'(1);
            j_reg     <= '0;
            comp_reg  <= '0;
            op_reg    <= OP_A0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sps_reg   <= sps_next;
            held_reg  <= held_next;
            seg2_reg  <= seg2_next;
            len_reg   <= len_next;
            j_reg     <= j_next;
            comp_reg  <= comp_next;
            op_reg    <= op_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w0_reg <= w0_next;
        w1_reg <= w1_next;
        w2_reg <= w2_next;
        q0_reg <= q0_next;
        q1_reg <= q1_next;
        q2_reg <= q2_next;
        q3_reg <= q3_next;
        t_reg  <= t_next;
        a0_reg <= a0_next;
        a1_reg <= a1_next;
        a2_reg <= a2_next;
        b0_reg <= b0_next;
        b1_reg <= b1_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        cs_reg <= cs_next;
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        oz_reg <= oz_next;
        os_reg <= os_next;
        oe_reg <= oe_next;
    end

    assign samples.valid      = ov_reg;
    assign samples.out_x      = ox_reg;
    assign samples.out_y      = oy_reg;
    assign samples.out_z      = oz_reg;
    assign samples.out_scale  = os_reg;
    assign samples.end_of_run = oe_reg;

endmodule
